// ===== hdl/assert_macros.svh =====
// Assertion macros used by huffman_bit_packer.sv.
// Each macro checks a property on the rising edge of a clock.
// HBP_ASSERT is disabled while the active-low reset is asserted.
// HBP_ASSERT_ALWAYS is also checked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HBP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HBP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HBP_ASSERT(label, clk, rst_n, prop, msg)

`define HBP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/hbp_pkg.sv =====
`default_nettype none

package hbp_pkg;

  // Table size and code length bounds
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LEN_W        = $clog2(LEN_LIMIT + 1);
  localparam int SYM_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Byte accumulator
  localparam int BYTE_W = 8;
  localparam int FB_W   = 4;
  localparam int CNT_W  = (LEN_W > FB_W) ? LEN_W : FB_W;
  localparam logic [FB_W-1:0] FB_EMPTY = FB_W'(BYTE_W);

  // Input field widths
  localparam int CMD_W     = 2;
  localparam int SYM_W     = 8;
  localparam int IN_LEN_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_PACK,
    S_FLUSH_DATA,
    S_FLUSH_TAIL
  } state_t;

  // Table read result
  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_rd_t;

  // Request to the merge unit
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  rem;
    logic [FB_W-1:0]   free;
    logic [BYTE_W-1:0] pending;
  } pack_req_t;

  // Result of one merge step
  typedef struct packed {
    logic [LEN_W-1:0]  rem;
    logic [FB_W-1:0]   free;
    logic [BYTE_W-1:0] pending;
    logic              byte_done;
  } pack_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/hbp_in_if.sv =====
`default_nettype none

interface hbp_in_if
  import hbp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SYM_W-1:0]    symbol;
  logic [IN_LEN_W-1:0] code_length;
  logic [CODE_W-1:0]   code_bits;

  modport source (output valid, command, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, command, symbol, code_length, code_bits, output ready);
endinterface

`default_nettype wire

// ===== hdl/hbp_out_if.sv =====
`default_nettype none

interface hbp_out_if
  import hbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/hbp_code_store.sv =====
`default_nettype none

module hbp_code_store
  import hbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [SYM_AW-1:0] wr_addr,
  input  wire logic [LEN_W-1:0]  wr_len,
  input  wire logic [CODE_W-1:0] wr_code,
  input  wire logic              rd_en,
  input  wire logic [SYM_AW-1:0] rd_addr,
  output tbl_rd_t                rd_data
);

  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;

  logic              rd_valid_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [CODE_W-1:0] rd_code_r;

  // Mark written entries; an unmarked entry reads with valid low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Write and registered read of the length and code tables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem[wr_addr]  <= wr_len;
      code_mem[wr_addr] <= wr_code;
    end
    if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
      rd_len_r   <= len_mem[rd_addr];
      rd_code_r  <= code_mem[rd_addr];
    end
  end

  assign rd_data.valid = rd_valid_r;
  assign rd_data.len   = rd_len_r;
  assign rd_data.code  = rd_code_r;

endmodule

`default_nettype wire

// ===== hdl/hbp_merge_unit.sv =====
`default_nettype none

module hbp_merge_unit
  import hbp_pkg::*;
(
  input  wire pack_req_t req,
  output pack_rsp_t      rsp
);

  logic [CNT_W-1:0]  rem_e;
  logic [CNT_W-1:0]  free_e;
  logic [CNT_W-1:0]  take_e;
  logic [FB_W-1:0]   take;
  logic [LEN_W-1:0]  shamt;
  logic [CODE_W-1:0] shifted;
  logic [BYTE_W:0]   mask9;
  logic [BYTE_W-1:0] chunk;
  logic [FB_W-1:0]   free_new;

  // Take as many code bits as fit into the free part of the byte
  always_comb begin
    rem_e    = CNT_W'(req.rem);
    free_e   = CNT_W'(req.free);
    take_e   = (rem_e < free_e) ? rem_e : free_e;
    take     = take_e[FB_W-1:0];
    shamt    = req.rem - LEN_W'(take);
    shifted  = req.code >> shamt;
    mask9    = ((BYTE_W+1)'(1) << take) - (BYTE_W+1)'(1);
    chunk    = shifted[BYTE_W-1:0] & mask9[BYTE_W-1:0];
    free_new = req.free - take;

    rsp.rem       = shamt;
    rsp.free      = free_new;
    rsp.pending   = req.pending | (chunk << (req.free - take));
    rsp.byte_done = (free_new == '0);
  end

endmodule

`default_nettype wire

// ===== hdl/huffman_bit_packer.sv =====
// Channel  Dir  Payload                                   Handshake
// in_chan  in   command, symbol, code_length, code_bits   valid/ready
// out_chan out  out_byte, last_of_run                     valid/ready
//
// A load writes the table when accepted. An encode is accepted in idle,
// reads the table in S_LOOK, then in S_PACK takes one merge-unit step per
// completed byte plus one for any leftover bits, then returns to idle.
// A flush emits the pending byte and, if bits were pending, a tail byte.
// Reset clears the table valid bits and the accumulator.
// A full output register stalls the merge step that completes a byte.
`default_nettype none

`include "assert_macros.svh"

module huffman_bit_packer
  import hbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  hbp_in_if.sink    in_chan,
  hbp_out_if.source out_chan
);

  state_t state_r, state_nxt;

  logic [BYTE_W-1:0] pending_r, pending_nxt;
  logic [FB_W-1:0]   free_bits_r, free_bits_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic             in_fire;
  logic             sym_ok;
  logic             can_emit;
  logic [LEN_W-1:0] load_len;

  tbl_rd_t   tbl_rd;
  pack_req_t mreq;
  pack_rsp_t mrsp;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign sym_ok        = (int'(in_chan.symbol) < SYMBOL_COUNT);
  assign can_emit      = !out_valid_r || out_chan.ready;

  // Saturate the loaded code length
  assign load_len = (int'(in_chan.code_length) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT)
                                                            : LEN_W'(in_chan.code_length);

  hbp_code_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && (in_chan.command == CMD_LOAD) && sym_ok),
    .wr_addr (in_chan.symbol[SYM_AW-1:0]),
    .wr_len  (load_len),
    .wr_code (in_chan.code_bits),
    .rd_en   (in_fire && (in_chan.command == CMD_ENCODE) && sym_ok),
    .rd_addr (in_chan.symbol[SYM_AW-1:0]),
    .rd_data (tbl_rd)
  );

  assign mreq.code    = code_r;
  assign mreq.rem     = rem_r;
  assign mreq.free    = free_bits_r;
  assign mreq.pending = pending_r;

  hbp_merge_unit u_merge (
    .req (mreq),
    .rsp (mrsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.command)
            CMD_ENCODE: state_nxt = sym_ok ? S_LOOK : S_IDLE;
            CMD_FLUSH:  state_nxt = S_FLUSH_DATA;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: state_nxt = S_PACK;
      S_PACK: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH_DATA: begin
        if (can_emit) begin
          state_nxt = (free_bits_r < FB_EMPTY) ? S_FLUSH_TAIL : S_IDLE;
        end
      end
      S_FLUSH_TAIL: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    pending_nxt   = pending_r;
    free_bits_nxt = free_bits_r;
    rem_nxt       = rem_r;
    code_nxt      = code_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: ;
      S_LOOK: begin
        rem_nxt  = tbl_rd.valid ? tbl_rd.len : '0;
        code_nxt = tbl_rd.code;
      end
      S_PACK: begin
        if (rem_r != '0) begin
          if (!mrsp.byte_done) begin
            pending_nxt   = mrsp.pending;
            free_bits_nxt = mrsp.free;
            rem_nxt       = mrsp.rem;
          end else if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = mrsp.pending;
            out_last_nxt  = (int'(mrsp.rem) < BYTE_W);
            pending_nxt   = '0;
            free_bits_nxt = FB_EMPTY;
            rem_nxt       = mrsp.rem;
          end
        end
      end
      S_FLUSH_DATA: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pending_r;
          out_last_nxt  = !(free_bits_r < FB_EMPTY);
          if (!(free_bits_r < FB_EMPTY)) begin
            pending_nxt = '0;
          end
        end
      end
      S_FLUSH_TAIL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = BYTE_W'(free_bits_r);
          out_last_nxt  = 1'b1;
          pending_nxt   = '0;
          free_bits_nxt = FB_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // Control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pending_r   <= '0;
      free_bits_r <= FB_EMPTY;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pending_r   <= pending_nxt;
      free_bits_r <= free_bits_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.last_of_run = out_last_r;

  // Free count stays within one byte
  `HBP_ASSERT(a_free_range, clk, rst_n,
              (free_bits_r >= 4'd1) && (free_bits_r <= FB_EMPTY),
              "free bit count out of range")

  // Unused low bits of the pending byte stay zero
  `HBP_ASSERT(a_pending_clean, clk, rst_n,
              (({1'b0, pending_r} & ((9'd1 << free_bits_r) - 9'd1)) == 9'd0),
              "pending byte has bits in its free part")

  // A completed flush leaves an empty accumulator
  `HBP_ASSERT(a_flush_clears, clk, rst_n,
              (state_r == S_FLUSH_TAIL) && can_emit |=>
                (free_bits_r == FB_EMPTY) && (pending_r == '0),
              "flush left bits pending")

  // Input is refused while an item is in progress
  `HBP_ASSERT(a_busy_refuse, clk, rst_n,
              (state_r == S_PACK) && (rem_r != '0) |-> !in_chan.ready,
              "input taken during packing")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb
  import hbp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 140;
  localparam int HOLD_CYCLES  = 120;
  localparam int POOL_SIZE    = 12;

  // Command code that the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // One predicted output byte
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_byte_t;

  // Tracks the code table and bit accumulator, queues the bytes they produce
  class packer_scoreboard;
    logic [IN_LEN_W-1:0] len_tab [SYMBOL_COUNT];
    logic [CODE_W-1:0]   code_tab [SYMBOL_COUNT];
    logic [BYTE_W-1:0]   acc_byte;
    logic [FB_W-1:0]     acc_free;
    packed_byte_t        want_q [$];
    int                  errors;

    function new();
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        len_tab[i]  = '0;
        code_tab[i] = '0;
      end
      acc_byte = '0;
      acc_free = FB_EMPTY;
      errors   = 0;
    endfunction

    // Append one predicted byte at the back of the queue
    function void queue_byte(logic [BYTE_W-1:0] value, logic last);
      packed_byte_t w;
      w.value = value;
      w.last  = last;
      want_q.insert(want_q.size(), w);
    endfunction

    // Update the table or the accumulator for one accepted transaction
    function void note_command(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                               logic [IN_LEN_W-1:0] len, logic [CODE_W-1:0] bits);
      int           n;
      int           l;
      logic [CODE_W-1:0] c;
      n = 0;
      if (cmd == CMD_LOAD) begin
        if (len > LEN_LIMIT) len = IN_LEN_W'(LEN_LIMIT);
        len_tab[sym]  = len;
        code_tab[sym] = bits;
      end else if (cmd == CMD_ENCODE) begin
        l = len_tab[sym];
        c = code_tab[sym];
        // shift the code in MSB first, emit each full byte
        for (int i = l - 1; i >= 0; i--) begin
          acc_free = acc_free - 1'b1;
          acc_byte[acc_free[2:0]] = c[i];
          if (acc_free == 0) begin
            queue_byte(acc_byte, 1'b0);
            n++;
            acc_byte = '0;
            acc_free = FB_EMPTY;
          end
        end
        // flag the final byte of this transaction
        if (n > 0) begin
          want_q[want_q.size() - 1].last = 1'b1;
        end
      end else if (cmd == CMD_FLUSH) begin
        if (acc_free < FB_EMPTY) begin
          queue_byte(acc_byte, 1'b0);
          queue_byte(BYTE_W'(acc_free), 1'b1);
        end else begin
          queue_byte(BYTE_W'(0), 1'b1);
        end
        acc_byte = '0;
        acc_free = FB_EMPTY;
      end
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one output transaction with the oldest predicted byte
    task check_byte(logic [BYTE_W-1:0] got_byte, logic got_last);
      packed_byte_t w;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got_byte, got_last));
      end else begin
        w = want_q.pop_front();
        if (got_byte !== w.value)
          report($sformatf("out_byte %02h, want %02h", got_byte, w.value));
        if (got_last !== w.last)
          report($sformatf("last_of_run %0b, want %0b (byte %02h)",
                           got_last, w.last, w.value));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hbp_in_if  in_chan ();
  hbp_out_if out_chan ();

  huffman_bit_packer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  packer_scoreboard sb = new();

  int hold_requests = 0;
  int cycle_count   = 0;

  always #5 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_command(in_chan.command, in_chan.symbol, in_chan.code_length,
                        in_chan.code_bits);
      if (out_chan.valid && out_chan.ready)
        sb.check_byte(out_chan.out_byte, out_chan.last_of_run);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver: switch between stall patterns, serve long hold-offs on request
  initial begin
    int rx_mode;
    int mode_cycles;
    int phase;
    int hold_left;
    int holds_served;
    rx_mode      = 0;
    mode_cycles  = 0;
    phase        = 0;
    hold_left    = 0;
    holds_served = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      mode_cycles++;
      if (mode_cycles == 40) begin
        mode_cycles = 0;
        rx_mode = $urandom_range(0, 3);
      end
      phase = (phase == 6) ? 0 : phase + 1;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready = 1'b0;
      end else begin
        case (rx_mode)
          0: out_chan.ready = 1'b1;
          1: out_chan.ready = ($urandom_range(0, 3) != 0);
          2: out_chan.ready = (phase > 2);
          default: out_chan.ready = $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task send(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym, logic [IN_LEN_W-1:0] len,
            logic [CODE_W-1:0] bits);
    @(negedge clk);
    in_chan.valid       = 1'b1;
    in_chan.command     = cmd;
    in_chan.symbol      = sym;
    in_chan.code_length = len;
    in_chan.code_bits   = bits;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
  endtask

  // Hold the sender until every predicted byte has arrived
  task wait_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (sb.want_q.size() != 0) @(negedge clk);
  endtask

  function logic [IN_LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return IN_LEN_W'($urandom_range(33, 63));
    if (r < 6)  return IN_LEN_W'($urandom_range(17, 32));
    return IN_LEN_W'($urandom_range(1, 16));
  endfunction

  // Stimulus
  initial begin
    logic [SYM_W-1:0] pool [POOL_SIZE];
    int counted;
    int burst_left;
    int r;
    bit held;
    bit paused;
    counted    = 0;
    burst_left = 0;
    held       = 1'b0;
    paused     = 1'b0;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.command     = CMD_LOAD;
    in_chan.symbol      = '0;
    in_chan.code_length = '0;
    in_chan.code_bits   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // flush with nothing pending, encode of a never loaded symbol
    send(CMD_FLUSH, 8'h00, '0, '0);
    send(CMD_ENCODE, 8'h00, '0, '0);
    // loads: junk above the length, full length, saturated length, one bit, one byte
    send(CMD_LOAD, 8'h41, 6'd3, 32'hFFFF_FFF5);
    send(CMD_LOAD, 8'hFF, 6'd32, 32'hA5C3_96F0);
    send(CMD_LOAD, 8'h00, 6'd63, 32'hFFFF_FFFF);
    send(CMD_LOAD, 8'h10, 6'd1, 32'h0000_0000);
    send(CMD_LOAD, 8'h20, 6'd8, 32'h0000_005A);
    // unused command is dropped
    send(CMD_SPARE, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    // partial byte, then two four-byte encodes, then a flush with bits pending
    send(CMD_ENCODE, 8'h41, '0, '0);
    send(CMD_ENCODE, 8'hFF, '0, '0);
    send(CMD_ENCODE, 8'h00, '0, '0);
    send(CMD_FLUSH, 8'h00, '0, '0);
    // aligned single byte, then empty flush
    send(CMD_ENCODE, 8'h20, '0, '0);
    send(CMD_FLUSH, 8'h00, '0, '0);
    // length zero marks a symbol unused
    send(CMD_LOAD, 8'h41, 6'd0, 32'hFFFF_FFFF);
    send(CMD_ENCODE, 8'h41, '0, '0);
    // seven single bits leave one unused bit
    repeat (7) send(CMD_ENCODE, 8'h10, '0, '0);
    send(CMD_FLUSH, 8'h00, '0, '0);
    wait_drained();

    // load a pool of live symbols first
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = SYM_W'($urandom_range(0, 255));
      send(CMD_LOAD, pool[i], IN_LEN_W'($urandom_range(1, 32)), $urandom);
      counted++;
    end

    // random mix in bursts, mostly encodes of live symbols
    while (counted < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        r = $urandom_range(0, 9);
        if (r > 3) idle_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      if (counted >= 60 && !held) begin
        held = 1'b1;
        hold_requests++;
      end
      if (counted >= 110 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send(CMD_SPARE, SYM_W'($urandom_range(0, 255)), IN_LEN_W'($urandom_range(0, 63)),
             $urandom);
      end else begin
        if (r < 26)
          send(CMD_LOAD, ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                                     : SYM_W'($urandom_range(0, 255)),
               pick_length(), $urandom);
        else if (r < 36)
          send(CMD_FLUSH, SYM_W'($urandom_range(0, 255)), IN_LEN_W'($urandom_range(0, 63)),
               $urandom);
        else
          send(CMD_ENCODE, ($urandom_range(0, 6) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                                       : SYM_W'($urandom_range(0, 255)),
               IN_LEN_W'($urandom_range(0, 63)), $urandom);
        counted++;
      end
    end
    send(CMD_FLUSH, 8'h00, '0, '0);

    // let the last transactions finish and catch stray bytes
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/hbp_pkg.sv
hdl/hbp_in_if.sv
hdl/hbp_out_if.sv
hdl/hbp_code_store.sv
hdl/hbp_merge_unit.sv
hdl/huffman_bit_packer.sv
tb/sv/tb.sv
